// ===== hw/rtl/acbc_pkg.sv =====
// Package: beat types, S-box tables and AES round functions.
`timescale 1ns / 1ps
`default_nettype none
package acbc_pkg;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        start_message;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  localparam logic [1:0] MODE_CBC_DEC = 2'd0;
  localparam logic [1:0] MODE_CBC_ENC = 2'd1;

  localparam int unsigned NUM_ROUNDS = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(s, r + 4 * c);
        end else begin
          o[127 - 8 * (r + 4 * c) -: 8] = get_byte(s, r + 4 * ((c + r) % 4));
        end
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    logic [7:0]   x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
      y0 = xt(x0); y1 = xt(x1); y2 = xt(x2); y3 = xt(x3);
      z0 = xt(y0); z1 = xt(y1); z2 = xt(y2); z3 = xt(y3);
      if (inv) begin
        o[127 - 32 * c -: 8]      = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1) ^ (z2 ^ y2 ^ a2) ^ (z3 ^ a3);
        o[127 - 32 * c - 8 -: 8]  = (z0 ^ a0) ^ (z1 ^ y1 ^ x1) ^ (z2 ^ x2 ^ a2) ^ (z3 ^ y3 ^ a3);
        o[127 - 32 * c - 16 -: 8] = (z0 ^ y0 ^ a0) ^ (z1 ^ a1) ^ (z2 ^ y2 ^ x2) ^ (z3 ^ x3 ^ a3);
        o[127 - 32 * c - 24 -: 8] = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1) ^ (z2 ^ a2) ^ (z3 ^ y3 ^ x3);
      end else begin
        o[127 - 32 * c -: 8]      = x0 ^ (x1 ^ a1) ^ a2 ^ a3;
        o[127 - 32 * c - 8 -: 8]  = a0 ^ x1 ^ (x2 ^ a2) ^ a3;
        o[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ x2 ^ (x3 ^ a3);
        o[127 - 32 * c - 24 -: 8] = (x0 ^ a0) ^ a1 ^ a2 ^ x3;
      end
    end
    mix_columns = o;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    next_round_key = {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/acbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module acbc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aes128_cbc_block_cipher.sv =====
// Top level: AES-128 block cipher with CBC decrypt, CBC encrypt and ECB encrypt.
`timescale 1ns / 1ps
`default_nettype none
// One 128-bit block per beat in, one result beat out. A block occupies the round
// datapath for one key addition and ten rounds, then the done state; the next
// block is taken once the result has moved to the output register. Round
// keys sit in an 11-entry RAM read one round ahead. After reset, and after every
// write to a key register, the key schedule fills that RAM, during which in_stall
// stays high. The chaining value reloads from the IV registers on a beat with
// start_message set.
module aes128_cbc_block_cipher
  import acbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int unsigned KEY_DEPTH = NUM_ROUNDS + 1;
  localparam int unsigned AW        = $clog2(KEY_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(NUM_ROUNDS);

  typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t          state_r;
  logic [AW-1:0]   cnt_r;
  logic [63:0]     key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [1:0]      mode_r;
  logic [127:0]    exp_r;
  logic [7:0]      rcon_r;
  logic [127:0]    s_r, chain_r, saved_r;
  logic            out_valid_r;
  out_beat_t       out_data_r;

  logic            in_fire, key_wr, dec;
  logic [127:0]    in_block, ch, rk, s_nxt, res, e_sr, d_ak;
  logic [AW-1:0]   step_rd, rd_addr;

  assign dec      = (mode_r == MODE_CBC_DEC);
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign key_wr   = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign in_block = {in_data.data_high, in_data.data_low};
  assign ch       = in_data.start_message ? {iv_high_r, iv_low_r} : chain_r;

  always_comb begin
    step_rd = (state_r == ST_RUN && cnt_r != LAST) ? cnt_r + AW'(1) : '0;
    rd_addr = dec ? LAST - step_rd : step_rd;
  end

  acbc_ram #(.WIDTH(128), .DEPTH(KEY_DEPTH)) u_rk_ram (
    .clk     (clk),
    .wr_en   (state_r == ST_EXPAND),
    .wr_addr (cnt_r),
    .wr_data (exp_r),
    .rd_addr (rd_addr),
    .rd_data (rk)
  );

  always_comb begin
    e_sr = shift_rows(sub_bytes(s_r, 1'b0), 1'b0);
    d_ak = sub_bytes(shift_rows(s_r, 1'b1), 1'b1) ^ rk;
    if (cnt_r == '0) begin
      s_nxt = s_r ^ rk;
    end else if (dec) begin
      s_nxt = (cnt_r != LAST) ? mix_columns(d_ak, 1'b1) : d_ak;
    end else begin
      s_nxt = ((cnt_r != LAST) ? mix_columns(e_sr, 1'b0) : e_sr) ^ rk;
    end
    res = dec ? s_r ^ chain_r : s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXPAND;
      cnt_r       <= '0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      mode_r      <= '0;
      exp_r       <= '0;
      rcon_r      <= 8'h01;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: key_high_r <= cfg_wdata;
          REG_KEY_LOW:  key_low_r  <= cfg_wdata;
          REG_IV_HIGH:  iv_high_r  <= cfg_wdata;
          REG_IV_LOW:   iv_low_r   <= cfg_wdata;
          REG_MODE:     mode_r     <= cfg_wdata[1:0];
          default:      ;
        endcase
      end
      case (state_r)
        ST_EXPAND: begin
          exp_r  <= next_round_key(exp_r, rcon_r);
          rcon_r <= xt(rcon_r);
          cnt_r  <= cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= ST_IDLE;
            cnt_r   <= '0;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
            chain_r <= ch;
            saved_r <= in_block;
            s_r     <= (mode_r == MODE_CBC_ENC) ? in_block ^ ch : in_block;
          end
        end
        ST_RUN: begin
          s_r   <= s_nxt;
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res[127:64], res[63:0]};
            if (dec) begin
              chain_r <= saved_r;
            end else if (mode_r == MODE_CBC_ENC) begin
              chain_r <= res;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (key_wr) begin
        state_r <= ST_EXPAND;
        cnt_r   <= '0;
        rcon_r  <= 8'h01;
        exp_r   <= {(cfg_index == REG_KEY_HIGH) ? cfg_wdata : key_high_r,
                    (cfg_index == REG_KEY_LOW)  ? cfg_wdata : key_low_r};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== tb/aes_cbc_checker.sv =====
// Checker: predicts AES-128 CBC/ECB results from watched beats and compares them.
`timescale 1ns / 1ps
module aes_cbc_checker
  import acbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_beat_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_beat_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);

  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
  logic [1:0]   cur_mode;
  logic [127:0] chain;
  logic [127:0] rk [11];
  out_beat_t    expected_q [$];

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] f);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (f[i]) r ^= a;
      a = mul2(a);
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] inv_sub(input logic [7:0] v);
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) return i[7:0];
    end
    return 8'h00;
  endfunction

  function automatic logic [127:0] round_mix(input logic [127:0] s, input bit inv);
    logic [127:0] o;
    logic [7:0]   m [4];
    logic [7:0]   v;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(byte_at(s, 4 * c + k), m[(k - r + 4) % 4]);
        o[127 - 8 * (4 * c + r) -: 8] = v;
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] rows_shift(input logic [127:0] s, input bit inv);
    logic [127:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = byte_at(s, r + 4 * c);
        else o[127 - 8 * (r + 4 * c) -: 8] = byte_at(s, r + 4 * ((c + r) % 4));
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] bytes_sub(input logic [127:0] s, input bit inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = inv ? inv_sub(byte_at(s, i)) : SBOX[byte_at(s, i)];
    end
    return o;
  endfunction

  task automatic schedule_keys();
    logic [7:0]  rc;
    logic [31:0] t;
    logic [127:0] k;
    rc = 8'h01;
    rk[0] = {key_hi, key_lo};
    for (int r = 1; r <= 10; r++) begin
      k = rk[r - 1];
      t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      rk[r][127:96] = k[127:96] ^ t;
      rk[r][95:64]  = k[95:64] ^ rk[r][127:96];
      rk[r][63:32]  = k[63:32] ^ rk[r][95:64];
      rk[r][31:0]   = k[31:0] ^ rk[r][63:32];
      rc = mul2(rc);
    end
  endtask

  function automatic logic [127:0] cipher(input logic [127:0] s);
    s ^= rk[0];
    for (int r = 1; r <= 10; r++) begin
      s = rows_shift(bytes_sub(s, 0), 0);
      if (r != 10) s = round_mix(s, 0);
      s ^= rk[r];
    end
    return s;
  endfunction

  function automatic logic [127:0] inv_cipher(input logic [127:0] s);
    s ^= rk[10];
    for (int r = 9; r >= 0; r--) begin
      s = bytes_sub(rows_shift(s, 1), 1) ^ rk[r];
      if (r != 0) s = round_mix(s, 1);
    end
    return s;
  endfunction

  task automatic predict_block(input in_beat_t b);
    logic [127:0] blk, res;
    out_beat_t e;
    blk = {b.data_high, b.data_low};
    if (b.start_message) chain = {iv_hi, iv_lo};
    if (cur_mode == MODE_CBC_DEC) begin
      res = inv_cipher(blk) ^ chain;
      chain = blk;
    end else if (cur_mode == MODE_CBC_ENC) begin
      res = cipher(blk ^ chain);
      chain = res;
    end else begin
      res = cipher(blk);
    end
    e.result_high = res[127:64];
    e.result_low = res[63:0];
    expected_q.push_back(e);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      cur_mode = MODE_CBC_DEC;
      chain = '0;
      schedule_keys();
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: begin key_hi = cfg_wdata; schedule_keys(); end
          REG_KEY_LOW: begin key_lo = cfg_wdata; schedule_keys(); end
          REG_IV_HIGH: iv_hi = cfg_wdata;
          REG_IV_LOW: iv_lo = cfg_wdata;
          REG_MODE: cur_mode = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_block(in_data);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          e = expected_q.pop_front();
          if (e.result_high !== out_data.result_high || e.result_low !== out_data.result_low) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h_%h got %h_%h", e.result_high,
                       e.result_low, out_data.result_high, out_data.result_low);
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives blocks and register writes into the AES-128 CBC cipher.
`timescale 1ns / 1ps
module testbench;
  import acbc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          mismatches;
  int          pending;
  int          quiet_cycles;
  bit          calm;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  aes128_cbc_block_cipher dut (.*);

  aes_cbc_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit first);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 8) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_high: hi, data_low: lo, start_message: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_all(input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] v0, input logic [63:0] v1, input logic [1:0] m);
    write_reg(REG_KEY_HIGH, k0);
    write_reg(REG_KEY_LOW, k1);
    write_reg(REG_IV_HIGH, v0);
    write_reg(REG_IV_LOW, v1);
    write_reg(REG_MODE, {62'd0, m});
  endtask

  initial begin
    logic [1:0] m;
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    drain();
    for (int md = 0; md < 4; md++) begin
      set_all(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0001020304050607,
              64'h08090a0b0c0d0e0f, md[1:0]);
      send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
      send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
      send_block('1, '0, 1'b0);
      send_block('0, '1, 1'b1);
      drain();
      write_reg(REG_UNUSED, '1);
    end
    write_reg(REG_IV_HIGH, '1);
    send_block(64'h1, 64'h2, 1'b0);
    drain();
    set_all('1, '1, '1, '1, MODE_CBC_ENC);
    send_block('1, '1, 1'b1);
    send_block('0, '0, 1'b0);
    drain();

    for (int p = 0; p < 12; p++) begin
      m = (p % 4 == 3) ? 2'd3 : 2'($urandom_range(2));
      set_all(rand64(), rand64(), rand64(), rand64(), m);
      calm = (p == 5);
      for (int n = 0; n < 104; n++) begin
        len = $urandom_range(9);
        send_block(rand64(), rand64(), len < 2 || n == 0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
